>>> rtl/thermal_plant_model_step_top_defines.svh
// Assertion macros shared by the checker of the thermal plant step block.
// No dependencies; include guard below.
`ifndef THERMAL_PLANT_MODEL_STEP_TOP_DEFINES_SVH
`define THERMAL_PLANT_MODEL_STEP_TOP_DEFINES_SVH
// Property checked at every clock edge outside reset.
`define TPMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every clock edge, reset included.
`define TPMS_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/tpms_pkg.sv
// Shared types, constants and tables of the thermal plant step block.
// No dependencies.
package tpms_pkg;

  localparam int DataW = 32;
  localparam int FracW = 16;
  localparam int AccW  = 64;
  localparam int RedW  = 48;
  localparam int CordW = 35;
  localparam int IdxW  = 5;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_COEF_A     = 3'd0;
  localparam logic [RegIdxW-1:0] REG_COEF_B     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_COEF_C     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_COEF_D     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_INIT_TEMP  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_INIT_DRIVE = 3'd5;

  localparam logic signed [DataW-1:0] RST_COEF_A     = 32'sd52429;
  localparam logic signed [DataW-1:0] RST_COEF_B     = 32'sd19661;
  localparam logic signed [DataW-1:0] RST_COEF_C     = 32'sd26214;
  localparam logic signed [DataW-1:0] RST_COEF_D     = 32'sd6554;
  localparam logic signed [DataW-1:0] RST_INIT_TEMP  = 32'sd1310720;
  localparam logic signed [DataW-1:0] RST_INIT_DRIVE = 32'sd327680;

  // Angle constants and the CORDIC gain in Q30, and the limit of the square term.
  localparam logic signed [RedW-1:0]  TWO_PI     = 48'sd6746518852;
  localparam logic signed [RedW-1:0]  PI_Q30     = 48'sd3373259426;
  localparam logic signed [RedW-1:0]  HALF_PI    = 48'sd1686629713;
  localparam logic signed [CordW-1:0] CORDIC_K   = 35'sd652032874;
  localparam logic signed [AccW-1:0]  SQ_LIMIT   = 64'sd1152921504606846976;

  // Sequencer step limits.
  localparam logic [IdxW-1:0] RED_FIRST = 5'd13;
  localparam logic [IdxW-1:0] CORD_LAST = 5'd29;
  localparam logic [IdxW-1:0] MUL_LAST  = 5'd8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RED, ST_FOLD, ST_CORD, ST_MUL, ST_FIN
  } tpms_state_t;

  typedef struct packed {
    logic            start;
    logic            red;
    logic            fold;
    logic            cord;
    logic            mul;
    logic            fin;
    logic [IdxW-1:0] idx;
  } tpms_cmd_t;

  typedef struct packed {
    logic out_busy;
  } tpms_stat_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [IdxW-1:0] i);
    logic signed [CordW-1:0] v;
    unique case (i)
      5'd0:  v = 35'sd843314857;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043837;
      5'd3:  v = 35'sd133525159;
      5'd4:  v = 35'sd67021687;
      5'd5:  v = 35'sd33543516;
      5'd6:  v = 35'sd16775851;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194283;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048576;
      5'd11: v = 35'sd524288;
      5'd12: v = 35'sd262144;
      5'd13: v = 35'sd131072;
      5'd14: v = 35'sd65536;
      5'd15: v = 35'sd32768;
      5'd16: v = 35'sd16384;
      5'd17: v = 35'sd8192;
      5'd18: v = 35'sd4096;
      5'd19: v = 35'sd2048;
      5'd20: v = 35'sd1024;
      5'd21: v = 35'sd512;
      5'd22: v = 35'sd256;
      5'd23: v = 35'sd128;
      5'd24: v = 35'sd64;
      5'd25: v = 35'sd32;
      5'd26: v = 35'sd16;
      5'd27: v = 35'sd8;
      5'd28: v = 35'sd4;
      5'd29: v = 35'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/thermal_plant_model_step_top.sv
// An item passes through the one-step-per-cycle sine unit (14 reduction steps, one fold,
// 30 CORDIC steps) and nine shared-multiplier steps; no new item is accepted until its
// result is issued to the output register.
// A finished result waits in the output register while the next item is already accepted.
// Reset (rst_n low at a clock edge) restores the register defaults, loads the history
// from them and empties the output register.
// Top level of the thermal plant step block; depends on tpms_pkg, tpms_ctrl and tpms_dp.
module thermal_plant_model_step_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] drive_input
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] temp_linear_out, [63:32] temp_nonlinear_out
  output logic        out_tuser   // [0] overflow
);
  import tpms_pkg::*;

  // Commands from the sequencer and the output-full status back to it.
  tpms_cmd_t  cmd;
  tpms_stat_t stat;

  logic signed [DataW-1:0] lin_q, nl_q;

  tpms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds configuration, history, the sine unit and the multiplier.
  tpms_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_drive   (signed'(in_tdata)),
    .in_restart (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_lin    (lin_q),
    .out_nl     (nl_q),
    .out_ovf    (out_tuser)
  );

  assign out_tdata = {nl_q, lin_q};

endmodule

>>> rtl/tpms_ctrl.sv
// Sequencer of the thermal plant step block: walks reduction, CORDIC and multiply steps.
// Depends on tpms_pkg.
module tpms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  tpms_pkg::tpms_stat_t stat,
  output tpms_pkg::tpms_cmd_t  cmd
);
  import tpms_pkg::*;

  tpms_state_t     state_r, state_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RED;
          cnt_nxt   = RED_FIRST;
        end
      end
      ST_RED: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FOLD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FOLD: begin
        state_nxt = ST_CORD;
        cnt_nxt   = '0;
      end
      ST_CORD: begin
        if (cnt_r == CORD_LAST) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cmd       = '0;
    cmd.idx   = cnt_r;
    cmd.start = (state_r == ST_IDLE) && in_tvalid;
    cmd.red   = (state_r == ST_RED);
    cmd.fold  = (state_r == ST_FOLD);
    cmd.cord  = (state_r == ST_CORD);
    cmd.mul   = (state_r == ST_MUL);
    cmd.fin   = (state_r == ST_FIN);
  end

endmodule

>>> rtl/tpms_dp.sv
// Datapath of the thermal plant step block: registers, history, sine unit, shared multiplier.
// Depends on tpms_pkg.
module tpms_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tpms_pkg::RegIdxW-1:0]    cfg_index,
  input  logic [tpms_pkg::DataW-1:0]      cfg_wdata,
  input  logic signed [tpms_pkg::DataW-1:0] in_drive,
  input  logic                            in_restart,
  input  tpms_pkg::tpms_cmd_t             cmd,
  output tpms_pkg::tpms_stat_t            stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [tpms_pkg::DataW-1:0] out_lin,
  output logic signed [tpms_pkg::DataW-1:0] out_nl,
  output logic                            out_ovf
);
  import tpms_pkg::*;

  logic signed [DataW-1:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r, init_t_r, init_d_r;
  logic signed [DataW-1:0] lin_t_r, cur_t_r, prv_t_r, prv_d_r, u_r;
  logic                    neg_r;
  logic [RedW-1:0]         r_r;
  logic signed [CordW-1:0] x_r, y_r, z_r;
  logic signed [AccW-1:0]  p_r, sq_r, bqh_r, lin_acc_r, nl_acc_r;
  logic                    clamp_r;
  logic                    out_valid_r;
  logic signed [DataW-1:0] out_lin_r, out_nl_r;
  logic                    out_ovf_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= RST_COEF_A;
      coef_b_r <= RST_COEF_B;
      coef_c_r <= RST_COEF_C;
      coef_d_r <= RST_COEF_D;
      init_t_r <= RST_INIT_TEMP;
      init_d_r <= RST_INIT_DRIVE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_A:     coef_a_r <= cfg_wdata;
        REG_COEF_B:     coef_b_r <= cfg_wdata;
        REG_COEF_C:     coef_c_r <= cfg_wdata;
        REG_COEF_D:     coef_d_r <= cfg_wdata;
        REG_INIT_TEMP:  init_t_r <= cfg_wdata;
        REG_INIT_DRIVE: init_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Start: history after an optional restart, and magnitude of the Q30 angle.
  logic signed [DataW-1:0] pd_eff;
  logic signed [RedW-1:0]  z_full;
  assign pd_eff = in_restart ? init_d_r : prv_d_r;
  assign z_full = {{(RedW-DataW-14){pd_eff[DataW-1]}}, pd_eff, 14'b0};

  // Modulo 2*pi: restoring subtraction of 2*pi shifted left by the step index.
  logic [RedW-1:0] red_sh;
  assign red_sh = RedW'(TWO_PI) << cmd.idx[3:0];

  // Fold the reduced angle into [-pi/2, pi/2].
  logic signed [RedW-1:0] zw, zf, zc;
  always_comb begin
    zw = (neg_r && (r_r != '0)) ? (TWO_PI - signed'(r_r)) : signed'(r_r);
    zf = (zw > PI_Q30) ? (zw - TWO_PI) : zw;
    if (zf > HALF_PI) begin
      zc = PI_Q30 - zf;
    end else if (zf < -HALF_PI) begin
      zc = -PI_Q30 - zf;
    end else begin
      zc = zf;
    end
  end

  // CORDIC rotation step.
  logic signed [CordW-1:0] dx, dy, ang;
  assign dx  = y_r >>> cmd.idx;
  assign dy  = x_r >>> cmd.idx;
  assign ang = atan_q30(cmd.idx);

  // Sine rounded half up to the Q16.16 grid.
  logic signed [CordW-1:0] y_rnd, y_sh;
  logic signed [DataW-1:0] sin_q;
  assign y_rnd = y_r + (CordW'(1) <<< 13);
  assign y_sh  = y_rnd >>> 14;
  assign sin_q = y_sh[DataW-1:0];

  // Shared multiplier operands.
  logic signed [DataW-1:0] ma, mb;
  logic signed [DataW-1:0] qh, ql;
  assign qh = signed'({1'b0, sq_r[62:32]});
  assign ql = signed'({16'b0, sq_r[31:16]});
  always_comb begin
    unique case (cmd.idx[2:0])
      3'd0: begin ma = prv_t_r;  mb = prv_t_r; end
      3'd1: begin ma = coef_a_r; mb = lin_t_r; end
      3'd2: begin ma = coef_b_r; mb = qh;      end
      3'd3: begin ma = coef_b_r; mb = ql;      end
      3'd4: begin ma = coef_b_r; mb = u_r;     end
      3'd5: begin ma = coef_a_r; mb = cur_t_r; end
      3'd6: begin ma = coef_c_r; mb = u_r;     end
      default: begin ma = coef_d_r; mb = sin_q; end
    endcase
  end

  logic signed [AccW-1:0] p_sh, sq_term;
  logic [IdxW-1:0]        acc_k;
  assign p_sh    = p_r >>> FracW;
  assign acc_k   = cmd.idx - 1'b1;
  assign sq_term = clamp_r ? (bqh_r[AccW-1] ? -SQ_LIMIT : SQ_LIMIT) : (bqh_r + p_sh);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_r <= pd_eff[DataW-1] ? unsigned'(-z_full) : unsigned'(z_full);
    end
    if (cmd.red && (r_r >= red_sh)) begin
      r_r <= r_r - red_sh;
    end
    if (cmd.fold) begin
      x_r <= CORDIC_K;
      y_r <= '0;
      z_r <= zc[CordW-1:0];
    end
    if (cmd.cord) begin
      if (!z_r[CordW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end
    end
    if (cmd.mul) begin
      if (cmd.idx != MUL_LAST) begin
        p_r <= AccW'(ma) * AccW'(mb);
      end
      if (cmd.idx != '0) begin
        unique case (acc_k[2:0])
          3'd0: sq_r <= p_r;
          3'd1: lin_acc_r <= p_sh;
          3'd2: begin
            bqh_r   <= p_r;
            clamp_r <= (p_r > SQ_LIMIT) || (p_r < -SQ_LIMIT);
          end
          3'd3: nl_acc_r <= -sq_term;
          3'd4: lin_acc_r <= lin_acc_r + p_sh;
          default: nl_acc_r <= nl_acc_r + p_sh;
        endcase
      end
    end
  end

  // Saturation to 32 bits.
  localparam logic signed [AccW-1:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [AccW-1:0] SAT_LO = -64'sd2147483648;
  logic signed [DataW-1:0] lin_sat, nl_sat;
  logic                    lin_ovf, nl_ovf;
  always_comb begin
    lin_ovf = (lin_acc_r > SAT_HI) || (lin_acc_r < SAT_LO);
    nl_ovf  = (nl_acc_r > SAT_HI) || (nl_acc_r < SAT_LO);
    lin_sat = lin_acc_r[DataW-1:0];
    nl_sat  = nl_acc_r[DataW-1:0];
    if (lin_acc_r > SAT_HI) lin_sat = SAT_HI[DataW-1:0];
    if (lin_acc_r < SAT_LO) lin_sat = SAT_LO[DataW-1:0];
    if (nl_acc_r > SAT_HI)  nl_sat  = SAT_HI[DataW-1:0];
    if (nl_acc_r < SAT_LO)  nl_sat  = SAT_LO[DataW-1:0];
  end

  logic fin_go;
  assign fin_go        = cmd.fin && !(out_valid_r && !out_ready);
  assign stat.out_busy = out_valid_r && !out_ready;

  // History: loaded at reset, reloaded on restart, shifted when a result is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_t_r <= RST_INIT_TEMP;
      cur_t_r <= RST_INIT_TEMP;
      prv_t_r <= RST_INIT_TEMP;
      prv_d_r <= RST_INIT_DRIVE;
    end else if (cmd.start) begin
      if (in_restart) begin
        lin_t_r <= init_t_r;
        cur_t_r <= init_t_r;
        prv_t_r <= init_t_r;
        prv_d_r <= init_d_r;
      end
    end else if (fin_go) begin
      lin_t_r <= lin_sat;
      prv_t_r <= cur_t_r;
      cur_t_r <= nl_sat;
      prv_d_r <= u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      u_r   <= in_drive;
      neg_r <= pd_eff[DataW-1];
    end
    if (fin_go) begin
      out_lin_r <= lin_sat;
      out_nl_r  <= nl_sat;
      out_ovf_r <= lin_ovf || nl_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_lin   = out_lin_r;
  assign out_nl    = out_nl_r;
  assign out_ovf   = out_ovf_r;

endmodule

>>> rtl/tpms_checker.sv
// Port-level checker of the thermal plant step block, bound to the top level.
// Depends on thermal_plant_model_step_top_defines.svh.
`include "thermal_plant_model_step_top_defines.svh"
module tpms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);
  // Only one item is in work at a time.
  `TPMS_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accepted while busy")
  // A result appears only while the block is still busy with its item.
  `TPMS_ASSERT(a_out_rise_busy, $rose(out_tvalid) |-> !$past(in_tready), "result without item")
  `TPMS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `TPMS_ASSERT_ALL(a_rst_empty, !$past(rst_n) |-> !out_tvalid, "result after reset")
endmodule

bind thermal_plant_model_step_top tpms_checker u_tpms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
